>>> hw/rtl/cr2b_pkg.sv
package cr2b_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_WIDTH = 32;
	localparam int SCALE_W     = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = DIFF_W + SCALE_W;
	localparam int TERM_W      = PROD_W - FRAC_BITS;
	localparam int TERM_S_W    = TERM_W + 1;
	localparam int SUM_W       = TERM_S_W + 1;
	localparam int CFG_W       = (COORD_WIDTH > SCALE_W) ? COORD_WIDTH : SCALE_W;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_AXES    = 3;
	localparam int NUM_LANES   = 2 * NUM_AXES;

	localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(21845);

	// segment queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// axis order inside a point
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [NUM_AXES-1:0] point_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X,
		CFG_START_Y,
		CFG_START_Z,
		CFG_END_X,
		CFG_END_Y,
		CFG_END_Z,
		CFG_SCALE
	} cfg_reg_t;

	// one segment for the back end: p1 -> p2 with neighbours p0 and p3
	typedef struct packed {
		point_t p0;
		point_t p1;
		point_t p2;
		point_t p3;
		logic   final_seg;
		logic   err;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> hw/rtl/cr2b_queue.sv
module cr2b_queue import cr2b_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t stat
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QPTR_W'((QPTR_W + 1)'(wr_ptr_q) + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= QPTR_W'((QPTR_W + 1)'(rd_ptr_q) + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/cr2b_front.sv
module cr2b_front import cr2b_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  point_t  in_point,
	input  logic    in_last,
	input  point_t  start_ctrl,
	input  point_t  end_ctrl,
	input  q_stat_t q_stat,
	output logic    push,
	output job_t    push_job
);

	point_t     win_q [3];
	logic [1:0] seen_q;
	job_t       hold_q;
	logic       hold_valid_q;

	logic accept;
	logic has_a;
	job_t job_a;
	job_t job_b;

	assign in_ready = !hold_valid_q && !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign has_a    = seen_q[1];

	// pending segment and closing segment for the incoming point
	always_comb begin
		job_a.p0        = (seen_q == 2'd3) ? win_q[0] : start_ctrl;
		job_a.p1        = win_q[1];
		job_a.p2        = win_q[2];
		job_a.p3        = in_point;
		job_a.final_seg = 1'b0;
		job_a.err       = 1'b0;

		if (seen_q == 2'd0) begin
			job_b = '0;
			job_b.final_seg = 1'b1;
			job_b.err       = 1'b1;
		end else begin
			job_b.p0        = has_a ? win_q[1] : start_ctrl;
			job_b.p1        = win_q[2];
			job_b.p2        = in_point;
			job_b.p3        = end_ctrl;
			job_b.final_seg = 1'b1;
			job_b.err       = 1'b0;
		end
	end

	// queue write: held closing segment first, else the new request
	always_comb begin
		if (hold_valid_q) begin
			push     = !q_stat.full;
			push_job = hold_q;
		end else begin
			push     = accept && (has_a || in_last);
			push_job = has_a ? job_a : job_b;
		end
	end

	// closing segment held back when a request gives two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (hold_valid_q) begin
			hold_valid_q <= q_stat.full;
		end else begin
			hold_valid_q <= accept && has_a && in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= job_b;
		end
	end

	// sliding window of anchors
	always_ff @(posedge clk) begin
		if (accept && !in_last) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= in_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				seen_q <= '0;
			end else if (seen_q != 2'd3) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/cr2b_back.sv
module cr2b_back import cr2b_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            q_stat,
	input  job_t               head,
	output logic               pop,
	input  logic [SCALE_W-1:0] scale,
	output logic               out_valid,
	input  logic               out_ready,
	output point_t             first_ctrl,
	output point_t             second_ctrl,
	output point_t             seg_end,
	output logic               final_seg,
	output logic               err
);

	logic   adv;
	logic   valid_s1, valid_s2, valid_s3, out_valid_q;
	point_t end_s1, end_s2, end_s3;
	logic   final_s1, final_s2, final_s3;
	logic   err_s1, err_s2, err_s3;

	coord_t res_q [NUM_LANES];
	point_t end_q;
	logic   final_q;
	logic   err_q;

	// whole pipeline moves when the output register is free or being read
	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !q_stat.empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !q_stat.empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// segment end and flags ride alongside the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			end_s1   <= head.p2;
			final_s1 <= head.final_seg;
			err_s1   <= head.err;
			end_s2   <= end_s1;
			final_s2 <= final_s1;
			err_s2   <= err_s1;
			end_s3   <= end_s2;
			final_s3 <= final_s2;
			err_s3   <= err_s2;
			end_q    <= err_s3 ? '0 : end_s3;
			final_q  <= final_s3;
			err_q    <= err_s3;
		end
	end

	// six lanes: first control per axis, then second control per axis
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		localparam int  AX   = l % NUM_AXES;
		localparam bit  BACK = (l >= NUM_AXES);

		coord_t                   base_c, a_c, b_c;
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0]        mag;
		logic [PROD_W-1:0]        rnd;
		logic [TERM_W-1:0]        t_mag;
		logic signed [TERM_S_W-1:0] term;
		logic signed [SUM_W-1:0]  sum;
		coord_t                   sat;

		coord_t                     base_s1, base_s2, base_s3;
		logic [DIFF_W-1:0]          mag_s1;
		logic                       flip_s1, flip_s2;
		logic [PROD_W-1:0]          prod_s2;
		logic signed [TERM_S_W-1:0] term_s3;

		// stage 1 operands: difference and its magnitude
		always_comb begin
			base_c = BACK ? head.p2[AX] : head.p1[AX];
			a_c    = BACK ? head.p3[AX] : head.p2[AX];
			b_c    = BACK ? head.p1[AX] : head.p0[AX];
			diff   = {a_c[COORD_WIDTH-1], a_c} - {b_c[COORD_WIDTH-1], b_c};
			mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		end

		// stage 3 operands: round half away from zero, restore sign
		always_comb begin
			rnd   = prod_s2 + ROUND_HALF;
			t_mag = rnd[PROD_W-1:FRAC_BITS];
			term  = flip_s2 ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
		end

		// output operands: add to anchor and saturate
		always_comb begin
			sum = $signed({{(SUM_W - COORD_WIDTH){base_s3[COORD_WIDTH-1]}}, base_s3})
				+ $signed({{(SUM_W - TERM_S_W){term_s3[TERM_S_W-1]}}, term_s3});
			if (sum[SUM_W-1:COORD_WIDTH-1] == '0
				|| sum[SUM_W-1:COORD_WIDTH-1] == '1) begin
				sat = sum[COORD_WIDTH-1:0];
			end else if (sum[SUM_W-1]) begin
				sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				base_s1 <= base_c;
				mag_s1  <= mag;
				flip_s1 <= diff[DIFF_W-1] ^ BACK;
				base_s2 <= base_s1;
				flip_s2 <= flip_s1;
				prod_s2 <= PROD_W'(mag_s1) * PROD_W'(scale);
				base_s3 <= base_s2;
				term_s3 <= term;
				res_q[l] <= err_s3 ? '0 : sat;
			end
		end
	end

	for (genvar c = 0; c < NUM_AXES; c++) begin : g_out
		assign first_ctrl[c]  = res_q[c];
		assign second_ctrl[c] = res_q[NUM_AXES + c];
	end

	assign seg_end   = end_q;
	assign final_seg = final_q;
	assign err       = err_q;

endmodule

>>> hw/rtl/catmull_rom_to_bezier.sv
// Streams 3D Q16.16 anchor points (one request per cycle while in_ready is
// high) and returns one cubic Bezier segment per anchor pair: two control
// points, the end anchor and flags. A segment leaves once the point after its
// pair has arrived; the point flagged last closes the path with the end
// control, and a last point with no predecessor yields one error result with
// all coordinates zero. The front end takes one point a cycle while the
// segment queue is not full; a last point that closes two segments holds the
// input until its held closing segment is written, because the segment queue
// takes one entry a cycle. The back end is a four-stage pipeline (difference,
// 33x32 multiply, rounding, saturating add) with six lanes. Write the
// configuration registers only while no point is in flight.
module catmull_rom_to_bezier import cr2b_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                   last_point,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [COORD_WIDTH-1:0] first_ctrl_x,
	output logic signed [COORD_WIDTH-1:0] first_ctrl_y,
	output logic signed [COORD_WIDTH-1:0] first_ctrl_z,
	output logic signed [COORD_WIDTH-1:0] second_ctrl_x,
	output logic signed [COORD_WIDTH-1:0] second_ctrl_y,
	output logic signed [COORD_WIDTH-1:0] second_ctrl_z,
	output logic signed [COORD_WIDTH-1:0] seg_end_x,
	output logic signed [COORD_WIDTH-1:0] seg_end_y,
	output logic signed [COORD_WIDTH-1:0] seg_end_z,
	output logic                   final_segment,
	output logic                   too_few_points
);

	point_t             start_q;
	point_t             end_ctrl_q;
	logic [SCALE_W-1:0] scale_q;

	point_t  in_point;
	q_stat_t q_stat;
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head;
	point_t  first_ctrl;
	point_t  second_ctrl;
	point_t  seg_end;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			end_ctrl_q <= '0;
			scale_q    <= SCALE_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_START_X: start_q[AXIS_X]    <= cfg_data[COORD_WIDTH-1:0];
				CFG_START_Y: start_q[AXIS_Y]    <= cfg_data[COORD_WIDTH-1:0];
				CFG_START_Z: start_q[AXIS_Z]    <= cfg_data[COORD_WIDTH-1:0];
				CFG_END_X:   end_ctrl_q[AXIS_X] <= cfg_data[COORD_WIDTH-1:0];
				CFG_END_Y:   end_ctrl_q[AXIS_Y] <= cfg_data[COORD_WIDTH-1:0];
				CFG_END_Z:   end_ctrl_q[AXIS_Z] <= cfg_data[COORD_WIDTH-1:0];
				CFG_SCALE:   scale_q            <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_point[AXIS_X] = point_x;
	assign in_point[AXIS_Y] = point_y;
	assign in_point[AXIS_Z] = point_z;

	cr2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_point   (in_point),
		.in_last    (last_point),
		.start_ctrl (start_q),
		.end_ctrl   (end_ctrl_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job)
	);

	cr2b_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	cr2b_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.scale       (scale_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_ctrl  (first_ctrl),
		.second_ctrl (second_ctrl),
		.seg_end     (seg_end),
		.final_seg   (final_segment),
		.err         (too_few_points)
	);

	assign first_ctrl_x  = first_ctrl[AXIS_X];
	assign first_ctrl_y  = first_ctrl[AXIS_Y];
	assign first_ctrl_z  = first_ctrl[AXIS_Z];
	assign second_ctrl_x = second_ctrl[AXIS_X];
	assign second_ctrl_y = second_ctrl[AXIS_Y];
	assign second_ctrl_z = second_ctrl[AXIS_Z];
	assign seg_end_x     = seg_end[AXIS_X];
	assign seg_end_y     = seg_end[AXIS_Y];
	assign seg_end_z     = seg_end[AXIS_Z];

`ifndef SYNTHESIS
	// an error result always closes the path, with zero x end, x first control and z second control
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_few_points |-> final_segment && seg_end_x == '0
			&& first_ctrl_x == '0 && second_ctrl_z == '0)
		else $error("error result not final or not zero");

	// a point is never taken while the segment queue is full
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !q_stat.full)
		else $error("point accepted with segment queue full");

	// the queue never pops an empty slot into the pipeline
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("segment popped from empty queue");
`endif

endmodule
